### hw/rtl/gfbt_pkg.sv
// gfbt_pkg: shared types and constants for the gossip freshness belief table
// holds the item structs, the action codes and the table sizing
// no dependencies
`default_nettype none

package gfbt_pkg;

  localparam int ENTRIES   = 3;
  localparam int TICK_W    = 32;
  localparam int LIMIT_W   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMP_W     = (TICK_W > LIMIT_W) ? TICK_W : LIMIT_W;

  localparam logic [6:0]         FRESH_MAX         = 7'd127;
  localparam logic [LIMIT_W-1:0] FRESH_LIMIT_RESET = 16'd64;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SENSE  = 2'd1,
    ACT_GOSSIP = 2'd2,
    ACT_READ   = 2'd3
  } act_t;

  typedef struct packed {
    act_t       action;
    logic [1:0] belt;
    logic [7:0] queue;
    logic       blocked;
    logic [6:0] freshness;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_queue;
    logic       out_blocked;
    logic [6:0] out_freshness;
    logic       is_fresh;
    logic       adopted;
  } out_item_t;

  typedef struct packed {
    logic [7:0]        queue;
    logic              blocked;
    logic [TICK_W-1:0] origin;
  } belief_t;

  // one item leaving the input register toward the table
  typedef struct packed {
    logic     fire;
    in_item_t item;
  } step_t;

endpackage

`default_nettype wire

### hw/rtl/gossip_freshness_belief_table.sv
// Gossip freshness belief table, top level.
//
// Keeps three belief entries (queue byte, blocked bit, origin tick) and a
// 32-bit wrapping tick counter. Each input item carries an action: tick,
// local sense, relayed gossip entry or read. Every item gives exactly one
// result item: read fields for a read, the adopted flag for gossip, zeros
// otherwise.
// Channels: in_valid/in_stall/in_data and out_valid/out_stall/out_data,
// an item moves on an edge with valid high and stall low. cfg_we writes
// cfg_wdata into the fresh limit; write it only while the block is idle.
//
// An accepted item is held in the input register and moves into the result
// register when that is free, and out_valid rises as it does. One item per
// cycle is sustained while out_stall is low; the table state is updated
// as an item moves into the result register, so the next item always sees it.
// When out_stall holds a full result register, one more item is taken into
// the input register and then in_stall rises until the result is taken.
// Synchronous reset clears all entries to unknown, the tick to zero, the
// fresh limit to 64 and both registers to empty.
// Depends on gfbt_pkg and gfbt_table.
`default_nettype none

module gossip_freshness_belief_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire gfbt_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output gfbt_pkg::out_item_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [gfbt_pkg::LIMIT_W-1:0]  cfg_wdata
);

  logic                 s1_valid_r, s1_valid_nxt;
  gfbt_pkg::in_item_t   s1_item_r;
  logic                 out_valid_r, out_valid_nxt;
  gfbt_pkg::out_item_t  out_data_r;
  logic                 out_free;
  logic                 advance;
  logic                 in_take;
  gfbt_pkg::step_t      step;
  gfbt_pkg::out_item_t  result;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

  assign step = '{fire: advance, item: s1_item_r};

  gfbt_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hw/rtl/gfbt_table.sv
// gfbt_table: belief entries, tick counter and fresh limit register
// computes the result of one item and updates state when it fires
// depends on gfbt_pkg
`default_nettype none

module gfbt_table (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire gfbt_pkg::step_t                step,
  input  wire logic                           cfg_we,
  input  wire logic [gfbt_pkg::LIMIT_W-1:0]   cfg_wdata,
  output gfbt_pkg::out_item_t                 result
);

  gfbt_pkg::belief_t                   belief_r [gfbt_pkg::ENTRIES];
  logic [gfbt_pkg::TICK_W-1:0]         tick_r;
  logic [gfbt_pkg::LIMIT_W-1:0]        limit_r;

  logic                                in_range;
  logic [gfbt_pkg::IDX_W-1:0]          idx;
  gfbt_pkg::belief_t                   cur;
  logic [7:0]                          g_age_p1;
  logic [gfbt_pkg::TICK_W-1:0]         g_origin;
  logic                                g_newer;
  logic [gfbt_pkg::TICK_W-1:0]         r_age;
  logic                                r_known;
  logic [6:0]                          r_sat;

  assign in_range = ({30'd0, step.item.belt} < 32'(gfbt_pkg::ENTRIES));
  assign idx      = gfbt_pkg::IDX_W'(step.item.belt);
  assign cur      = in_range ? belief_r[idx] : '0;

  // gossip: age + 1 = 128 - freshness, one tick allowed for the link
  assign g_age_p1 = 8'd128 - {1'b0, step.item.freshness};
  assign g_origin = (gfbt_pkg::TICK_W'(g_age_p1) >= tick_r) ? '0
                  : tick_r - gfbt_pkg::TICK_W'(g_age_p1);
  assign g_newer  = in_range && (g_origin > cur.origin);

  // read: age modulo the tick width, saturated at 127 on the wire
  assign r_age   = tick_r - cur.origin;
  assign r_known = in_range && (cur.origin != '0);
  assign r_sat   = (r_age > gfbt_pkg::TICK_W'(gfbt_pkg::FRESH_MAX)) ? gfbt_pkg::FRESH_MAX
                 : r_age[6:0];

  always_comb begin
    result = '0;
    unique case (step.item.action)
      gfbt_pkg::ACT_GOSSIP: begin
        result.adopted = g_newer;
      end
      gfbt_pkg::ACT_READ: begin
        if (in_range) begin
          result.out_queue   = cur.queue;
          result.out_blocked = cur.blocked;
        end
        if (r_known) begin
          result.out_freshness = gfbt_pkg::FRESH_MAX - r_sat;
          result.is_fresh      = (gfbt_pkg::CMP_W'(r_age) < gfbt_pkg::CMP_W'(limit_r));
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gfbt_pkg::ENTRIES; i++) begin
        belief_r[i] <= '0;
      end
      tick_r  <= '0;
      limit_r <= gfbt_pkg::FRESH_LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (step.fire) begin
        unique case (step.item.action)
          gfbt_pkg::ACT_TICK: begin
            tick_r <= tick_r + 1'b1;
          end
          gfbt_pkg::ACT_SENSE: begin
            if (in_range) begin
              belief_r[idx] <= '{queue: step.item.queue, blocked: step.item.blocked,
                                 origin: tick_r};
            end
          end
          gfbt_pkg::ACT_GOSSIP: begin
            if (g_newer) begin
              belief_r[idx] <= '{queue: step.item.queue, blocked: step.item.blocked,
                                 origin: g_origin};
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gfbt_checker.sv
// gfbt_checker: port-level checks for gossip_freshness_belief_table
// bound to the top level below; depends on gfbt_pkg
`default_nettype none

module gfbt_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire gfbt_pkg::out_item_t           out_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // backpressure only comes from a stalled full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // an accepted item reaches the output once the result register is free to take it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("accepted item did not reach the output");

  // a gossip result never carries read fields
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.adopted |-> (out_data.out_queue == 8'd0) &&
      !out_data.out_blocked && (out_data.out_freshness == 7'd0) && !out_data.is_fresh)
    else $error("adopted flag mixed with read fields");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind gossip_freshness_belief_table gfbt_checker u_gfbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
